// ----- sv/dtwm_pkg.sv -----
package dtwm_pkg;

   localparam int LIST_DEPTH = 16;
   localparam int LIST_AW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int LIST_CW    = $clog2(LIST_DEPTH + 1);
   localparam int WORD_W     = 32;
   localparam int MODE_W     = 2;

   localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MERGE  = 2'd2;

   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [LIST_CW-1:0] count_type;
   typedef logic [LIST_AW-1:0] addr_type;

endpackage

// ----- sv/descending_two_way_merge.sv -----
// descending two-way merge of two signed word lists
// request channel (req_): tuser carries the mode, tdata the signed word.
//    mode load A / load B appends the word to that list (dropped when full),
//    mode merge emits every loaded word as one descending run, list A first
//    on ties; an unused mode is ignored.
// result channel (rsp_): tdata is the merged word, tlast marks the final one.
// loads produce no result.
// a merge with n loaded words holds req_tready low and emits one word per
//    cycle while rsp_tready allows, the first once the request has passed
//    state and output register; with nothing loaded a merge emits nothing.
// the pace is set by the two list memories, one read port each, whose
//    registered read returns the next head word every cycle.
// the result sits in an output register; when the receiver stalls, the
//    merge halts with it and resumes when rsp_tready returns. loads are
//    accepted while the final word still waits to be taken.
// reset clears both counts, the merge state and the output valid flag;
//    list contents are not cleared and only written entries are ever picked.
module descending_two_way_merge
   import dtwm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic signed [WORD_W-1:0] req_tdata,  // value
   input  logic [MODE_W-1:0]        req_tuser,  // mode
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic signed [WORD_W-1:0] rsp_tdata,  // merged_value
   output logic                     rsp_tlast
);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_MERGE = 1'b1;

   logic      state_ff, state_in;
   count_type count_a_ff, count_a_in, count_b_ff, count_b_in;
   count_type ia_ff, ia_in, ib_ff, ib_in;
   logic      rsp_valid_ff, rsp_valid_in;
   word_type  rsp_data_ff, rsp_data_in;
   logic      rsp_last_ff, rsp_last_in;

   word_type  a_rd, b_rd, pick;
   logic      req_fire, load_a, load_b;
   logic      a_left, b_left, take_a, last_pick, advance;
   count_type ia_step, ib_step;

   dtwm_ram #(.WIDTH(WORD_W), .DEPTH(LIST_DEPTH)) u_ram_a (
      .clock   (clock),
      .wr_en   (load_a),
      .wr_addr (count_a_ff[LIST_AW-1:0]),
      .wr_data (word_type'(req_tdata)),
      .rd_addr (ia_in[LIST_AW-1:0]),
      .rd_data (a_rd)
   );

   dtwm_ram #(.WIDTH(WORD_W), .DEPTH(LIST_DEPTH)) u_ram_b (
      .clock   (clock),
      .wr_en   (load_b),
      .wr_addr (count_b_ff[LIST_AW-1:0]),
      .wr_data (word_type'(req_tdata)),
      .rd_addr (ib_in[LIST_AW-1:0]),
      .rd_data (b_rd)
   );

   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      req_fire   = req_tvalid && req_tready;
      load_a     = req_fire && (req_tuser == MODE_LOAD_A) &&
                   (count_a_ff < count_type'(LIST_DEPTH));
      load_b     = req_fire && (req_tuser == MODE_LOAD_B) &&
                   (count_b_ff < count_type'(LIST_DEPTH));

      a_left    = (ia_ff < count_a_ff);
      b_left    = (ib_ff < count_b_ff);
      take_a    = a_left && (!b_left || ($signed(a_rd) >= $signed(b_rd)));
      pick      = take_a ? a_rd : b_rd;
      ia_step   = ia_ff + count_type'(take_a);
      ib_step   = ib_ff + count_type'(!take_a);
      last_pick = (ia_step == count_a_ff) && (ib_step == count_b_ff);
      advance   = (state_ff == ST_MERGE) && (!rsp_valid_ff || rsp_tready);

      state_in     = state_ff;
      count_a_in   = count_a_ff;
      count_b_in   = count_b_ff;
      ia_in        = ia_ff;
      ib_in        = ib_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      if (load_a) begin
         count_a_in = count_a_ff + count_type'(1);
      end
      if (load_b) begin
         count_b_in = count_b_ff + count_type'(1);
      end
      if (req_fire && (req_tuser == MODE_MERGE) &&
          ((count_a_ff != '0) || (count_b_ff != '0))) begin
         state_in = ST_MERGE;
      end

      if (advance) begin
         ia_in        = ia_step;
         ib_in        = ib_step;
         rsp_valid_in = 1'b1;
         rsp_data_in  = pick;
         rsp_last_in  = last_pick;
         if (last_pick) begin
            state_in   = ST_IDLE;
            ia_in      = '0;
            ib_in      = '0;
            count_a_in = '0;
            count_b_in = '0;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         ia_ff        <= '0;
         ib_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         ia_ff        <= ia_in;
         ib_ff        <= ib_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = $signed(rsp_data_ff);
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- sv/dtwm_ram.sv -----
module dtwm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- sv/dtwm_checker.sv -----
module dtwm_checker
   import dtwm_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic [MODE_W-1:0]        req_tuser,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic signed [WORD_W-1:0] rsp_tdata,
   input logic                     rsp_tlast
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // no request taken while a merge run is still open
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request accepted during merge");

   // merge streams without gaps once a word is taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("gap inside merged run");

   // a load never produces a result on its own
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && req_tvalid && req_tready && (req_tuser != MODE_MERGE) |=> !rsp_tvalid)
      else $error("result without merge");

endmodule

bind descending_two_way_merge dtwm_checker u_dtwm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ----- tb/descending_two_way_merge_tb.sv -----
`timescale 1ns / 1ps

module descending_two_way_merge_tb;
   import dtwm_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int DIRECTED_ROWS = 23;
   localparam int RANDOM_ITEMS  = 210;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int TAIL_CYCLES   = 40;

   typedef struct packed {
      logic signed [WORD_W-1:0] word;
      logic                     is_last;
   } merged_word_t;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [WORD_W-1:0] value;
      int                reps;
      bit                typed;
      logic [WORD_W-1:0] typed_word;
   } stim_row_t;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic signed [WORD_W-1:0] req_tdata;
   logic [MODE_W-1:0]        req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic signed [WORD_W-1:0] rsp_tdata;
   logic                     rsp_tlast;

   logic signed [WORD_W-1:0] model_list_a [LIST_DEPTH];
   logic signed [WORD_W-1:0] model_list_b [LIST_DEPTH];
   int                       model_count_a;
   int                       model_count_b;
   merged_word_t             pending_merge_words [$];
   int                       error_count;
   bit                       no_idle;

   // reps > 1 loads value, value - 3, value - 6, ...
   stim_row_t directed_rows [DIRECTED_ROWS] = '{
      '{MODE_MERGE,  32'h0000_0000, 1,  1'b0, 32'h0},
      '{MODE_LOAD_A, 32'h7fff_ffff, 1,  1'b0, 32'h0},
      '{MODE_MERGE,  32'h0000_0000, 1,  1'b1, 32'h7fff_ffff},
      '{MODE_LOAD_B, 32'h8000_0000, 1,  1'b0, 32'h0},
      '{MODE_MERGE,  32'hffff_ffff, 1,  1'b1, 32'h8000_0000},
      '{MODE_UNUSED, 32'hffff_ffff, 1,  1'b0, 32'h0},
      '{MODE_MERGE,  32'h0000_0000, 1,  1'b0, 32'h0},
      '{MODE_UNUSED, 32'h0000_0000, 1,  1'b0, 32'h0},
      '{MODE_LOAD_B, 32'hffff_ffff, 1,  1'b0, 32'h0},
      '{MODE_MERGE,  32'h1234_5678, 1,  1'b1, 32'hffff_ffff},
      '{MODE_LOAD_A, 32'd100,       2,  1'b0, 32'h0},
      '{MODE_LOAD_B, 32'd100,       2,  1'b0, 32'h0},
      '{MODE_LOAD_B, 32'h8000_0000, 1,  1'b0, 32'h0},
      '{MODE_MERGE,  32'h0000_0000, 1,  1'b0, 32'h0},
      '{MODE_LOAD_A, 32'd1,         1,  1'b0, 32'h0},
      '{MODE_LOAD_A, 32'd50,        1,  1'b0, 32'h0},
      '{MODE_LOAD_B, 32'd20,        1,  1'b0, 32'h0},
      '{MODE_LOAD_B, 32'd30,        1,  1'b0, 32'h0},
      '{MODE_MERGE,  32'h0000_0000, 1,  1'b0, 32'h0},
      '{MODE_LOAD_A, 32'h5555_5555, 17, 1'b0, 32'h0},
      '{MODE_LOAD_B, 32'haaaa_aaaa, 1,  1'b0, 32'h0},
      '{MODE_LOAD_B, 32'h5555_5552, 1,  1'b0, 32'h0},
      '{MODE_MERGE,  32'hffff_ffff, 1,  1'b0, 32'h0}
   };

   descending_two_way_merge u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic predict_merge_request(input logic [MODE_W-1:0] mode,
                                        input logic signed [WORD_W-1:0] value,
                                        input bit record);
      int           ia;
      int           ib;
      int           total;
      bit           take_a;
      merged_word_t w;
      case (mode)
         MODE_LOAD_A: begin
            if (model_count_a < LIST_DEPTH) begin
               model_list_a[model_count_a] = value;
               model_count_a++;
            end
         end
         MODE_LOAD_B: begin
            if (model_count_b < LIST_DEPTH) begin
               model_list_b[model_count_b] = value;
               model_count_b++;
            end
         end
         MODE_MERGE: begin
            ia = 0;
            ib = 0;
            total = model_count_a + model_count_b;
            for (int k = 0; k < total; k++) begin
               if (ia >= model_count_a) begin
                  take_a = 1'b0;
               end else if (ib >= model_count_b) begin
                  take_a = 1'b1;
               end else begin
                  take_a = (model_list_a[ia] >= model_list_b[ib]);
               end
               if (take_a) begin
                  w.word = model_list_a[ia];
                  ia++;
               end else begin
                  w.word = model_list_b[ib];
                  ib++;
               end
               w.is_last = (k == total - 1);
               if (record) begin
                  pending_merge_words.push_back(w);
               end
            end
            model_count_a = 0;
            model_count_b = 0;
         end
         default: begin
         end
      endcase
   endtask

   // called right after a rising edge; returns right after the accepting edge
   task automatic send_request(input logic [MODE_W-1:0] mode,
                               input logic [WORD_W-1:0] value,
                               input bit record);
      if (!no_idle && $urandom_range(99) < 7) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= value;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      predict_merge_request(mode, value, record);
   endtask

   function automatic longint next_descending(input longint cur, input bit narrow);
      longint nxt;
      nxt = cur - (narrow ? longint'($urandom_range(2)) : longint'($urandom_range(32'h0fff_ffff)));
      if (nxt < -64'sd2147483648) begin
         nxt = -64'sd2147483648;
      end
      return nxt;
   endfunction

   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_tready <= no_idle || ($urandom_range(99) >= 7);
      end
   end

   always @(negedge clock) begin
      merged_word_t exp_w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_merge_words.size() == 0) begin
            $error("merged_value: expected none, actual %0d", rsp_tdata);
            error_count++;
         end else begin
            exp_w = pending_merge_words.pop_front();
            if (rsp_tdata !== exp_w.word) begin
               $error("merged_value: expected %0d, actual %0d", exp_w.word, rsp_tdata);
               error_count++;
            end
            if (rsp_tlast !== exp_w.is_last) begin
               $error("last: expected %0d, actual %0d", exp_w.is_last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   initial begin
      stim_row_t    row;
      merged_word_t typed_w;
      int           sent;
      int           na;
      int           nb;
      int           waited;
      bit           narrow;
      bit           pick_a;
      logic [MODE_W-1:0] m;
      longint       cur_a;
      longint       cur_b;

      error_count   = 0;
      no_idle       = 1'b0;
      model_count_a = 0;
      model_count_b = 0;
      sent          = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= MODE_LOAD_A;
      req_tdata  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         row = directed_rows[r];
         for (int i = 0; i < row.reps; i++) begin
            send_request(row.mode, row.value - WORD_W'(3 * i), !row.typed);
            if (row.typed) begin
               typed_w.word    = row.typed_word;
               typed_w.is_last = 1'b1;
               pending_merge_words.push_back(typed_w);
            end
         end
      end

      while (sent < RANDOM_ITEMS) begin
         no_idle = (sent >= 110 && sent < 190);
         if ($urandom_range(99) < 80) begin
            na = ($urandom_range(9) == 0) ? $urandom_range(16, 19) : $urandom_range(0, 16);
            nb = ($urandom_range(9) == 0) ? $urandom_range(16, 19) : $urandom_range(0, 16);
            narrow = ($urandom_range(2) == 0);
            cur_a = narrow ? longint'($urandom_range(20)) - 10 : longint'($signed($urandom));
            cur_b = narrow ? longint'($urandom_range(20)) - 10 : longint'($signed($urandom));
            while (na + nb > 0) begin
               if ($urandom_range(19) == 0) begin
                  send_request(MODE_UNUSED, $urandom, 1'b1);
               end
               pick_a = (nb == 0) || (na != 0 && $urandom_range(1) == 1);
               if (pick_a) begin
                  send_request(MODE_LOAD_A, cur_a[WORD_W-1:0], 1'b1);
                  cur_a = next_descending(cur_a, narrow);
                  na--;
               end else begin
                  send_request(MODE_LOAD_B, cur_b[WORD_W-1:0], 1'b1);
                  cur_b = next_descending(cur_b, narrow);
                  nb--;
               end
               sent++;
            end
            send_request(MODE_MERGE, $urandom, 1'b1);
            sent++;
         end else begin
            repeat ($urandom_range(1, 6)) begin
               m = MODE_W'($urandom_range(3));
               send_request(m, $urandom, 1'b1);
               if (m != MODE_UNUSED) begin
                  sent++;
               end
            end
         end
      end
      no_idle = 1'b0;
      send_request(MODE_MERGE, $urandom, 1'b1);
      req_tvalid <= 1'b0;

      waited = 0;
      while (pending_merge_words.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_merge_words.size() != 0) begin
         $error("merged_value: expected %0d more words, actual none",
                pending_merge_words.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ----- files.f -----
sv/dtwm_pkg.sv
sv/dtwm_ram.sv
sv/descending_two_way_merge.sv
sv/dtwm_checker.sv
tb/descending_two_way_merge_tb.sv
